// ===== design/ppbp_pkg.sv =====
// Shared types and constants for the pinhole person box projector.
// Holds the request structs, the divider lane structs and the register indexes.
// No dependencies.
package ppbp_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SKEW       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 3'd5;

	// Arithmetic widths
	localparam int PT_W   = 25;              // shifted point coordinate, signed
	localparam int NUM_W  = 42;              // projection numerator, signed
	localparam int MAG_W  = NUM_W - 1;       // numerator magnitude
	localparam int DEN_W  = 27;              // 16 * Z
	localparam int Q_W    = 17;              // quotient bits kept before saturation
	localparam int CMP_W  = DEN_W + Q_W - 1; // widest shifted divisor

	// Divider lanes
	localparam int NUM_LANES = 4;
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_W = 2;
	localparam int LANE_H = 3;

	typedef struct packed {
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic [17:0]        height;
		logic [15:0]        person_id;
	} item_t;

	typedef struct packed {
		logic signed [15:0] box_x;
		logic signed [15:0] box_y;
		logic [15:0]        box_w;
		logic [15:0]        box_h;
		logic [22:0]        depth;
		logic [17:0]        body_height;
		logic [15:0]        out_id;
	} box_t;

	// Fields that ride along with the division unchanged.
	typedef struct packed {
		logic [22:0] depth;
		logic [17:0] body_height;
		logic [15:0] out_id;
	} side_t;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} num_t;

	typedef struct packed {
		logic           neg;
		logic           ovf;
		logic [Q_W-1:0] quo;
	} quo_t;

endpackage

// ===== design/ppbp_div.sv =====
// Pipelined restoring divider for the four projection lanes sharing one divisor.
// One overflow stage, then one quotient bit per stage, with valid bits and sideband.
// Depends on ppbp_pkg.
module ppbp_div (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     en,
	input  logic                                     in_valid,
	input  logic [ppbp_pkg::DEN_W-1:0]               in_den,
	input  ppbp_pkg::num_t [ppbp_pkg::NUM_LANES-1:0] in_num,
	input  ppbp_pkg::side_t                          in_side,
	output logic                                     out_valid,
	output ppbp_pkg::quo_t [ppbp_pkg::NUM_LANES-1:0] out_quo,
	output ppbp_pkg::side_t                          out_side
);
	import ppbp_pkg::*;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [MAG_W-1:0] rem;
		logic [Q_W-1:0]   quo;
	} lane_t;

	// Stage 0 checks for quotient overflow; stage j settles quotient bit Q_W-j.
	logic                         valid_s [0:Q_W];
	logic [DEN_W-1:0]             den_s   [0:Q_W];
	side_t                        side_s  [0:Q_W];
	lane_t [NUM_LANES-1:0]        lane_s  [0:Q_W];
	lane_t [NUM_LANES-1:0]        step_lane [1:Q_W];
	lane_t [NUM_LANES-1:0]        first_lane;

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			first_lane[l].neg = in_num[l].neg;
			first_lane[l].ovf = ((in_num[l].mag >> Q_W) >= MAG_W'(in_den));
			first_lane[l].rem = in_num[l].mag;
			first_lane[l].quo = '0;
		end
	end

	always_comb begin
		logic [CMP_W-1:0] shd;
		for (int j = 1; j <= Q_W; j++) begin
			shd = CMP_W'(den_s[j-1]) << (Q_W - j);
			for (int l = 0; l < NUM_LANES; l++) begin
				step_lane[j][l] = lane_s[j-1][l];
				if (CMP_W'(lane_s[j-1][l].rem) >= shd) begin
					step_lane[j][l].rem = lane_s[j-1][l].rem - MAG_W'(shd);
					step_lane[j][l].quo = {lane_s[j-1][l].quo[Q_W-2:0], 1'b1};
				end else begin
					step_lane[j][l].quo = {lane_s[j-1][l].quo[Q_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= Q_W; j++) begin
				valid_s[j] <= 1'b0;
			end
		end else if (en) begin
			valid_s[0] <= in_valid;
			for (int j = 1; j <= Q_W; j++) begin
				valid_s[j] <= valid_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= in_den;
			side_s[0] <= in_side;
			lane_s[0] <= first_lane;
			for (int j = 1; j <= Q_W; j++) begin
				den_s[j]  <= den_s[j-1];
				side_s[j] <= side_s[j-1];
				lane_s[j] <= step_lane[j];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			out_quo[l].neg = lane_s[Q_W][l].neg;
			out_quo[l].ovf = lane_s[Q_W][l].ovf;
			out_quo[l].quo = lane_s[Q_W][l].quo;
		end
	end

	assign out_valid = valid_s[Q_W];
	assign out_side  = side_s[Q_W];

endmodule

// ===== design/pinhole_person_box_projector.sv =====
// Top level of the pinhole person box projector.
// Front end (point shift, products, sums, sign), the divider and the output skid.
// Depends on ppbp_pkg and ppbp_div.
module pinhole_person_box_projector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ppbp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ppbp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  ppbp_pkg::item_t                     item,
	output logic                                box_valid,
	input  logic                                box_ready,
	output ppbp_pkg::box_t                      box
);
	// Each request describes one tracked person: the camera-frame foot point
	// (X, Y, Z), the height and a track id. The block projects the top-left
	// point (X - half_width, Y - height, Z) and the bottom-right point
	// (X + half_width, Y, Z) through the pinhole intrinsics, all over the one
	// divisor 16*Z, and returns the top-left corner, the box width and height
	// (each the exact quotient truncated toward zero and saturated), the depth,
	// the height and the id. A request with Z at or below zero produces no
	// result. The block accepts one request every clock cycle unless stalled,
	// and a result passes 23 registers on its way out: four front-end
	// stages (point shift, multipliers, sums, sign and magnitude), eighteen
	// divider stages (an overflow check and then one quotient bit per stage
	// of a restoring divider, four lanes sharing one divisor) and the output
	// register. The output register is backed by a one-entry skid buffer, so
	// a request is still taken while a result waits; the input stalls only
	// once both hold a result. Configuration registers are to be written only
	// while the block is idle, which the block itself does not enforce, and
	// take effect on the next request.
	import ppbp_pkg::*;

	localparam logic [15:0] FOCAL_X_RST    = 16'd8000;
	localparam logic [15:0] FOCAL_Y_RST    = 16'd8000;
	localparam logic [15:0] CENTER_X_RST   = 16'd5120;
	localparam logic [15:0] CENTER_Y_RST   = 16'd3840;
	localparam logic [16:0] HALF_WIDTH_RST = 17'd19661;

	localparam logic [Q_W-1:0] POS_LIMIT = Q_W'(32767);
	localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(32768);

	// Configuration registers
	logic [15:0]        focal_x_q;
	logic [15:0]        focal_y_q;
	logic [15:0]        center_x_q;
	logic [15:0]        center_y_q;
	logic signed [15:0] skew_q;
	logic [16:0]        half_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q    <= FOCAL_X_RST;
			focal_y_q    <= FOCAL_Y_RST;
			center_x_q   <= CENTER_X_RST;
			center_y_q   <= CENTER_Y_RST;
			skew_q       <= '0;
			half_width_q <= HALF_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FOCAL_X:    focal_x_q    <= cfg_data[15:0];
				REG_FOCAL_Y:    focal_y_q    <= cfg_data[15:0];
				REG_CENTER_X:   center_x_q   <= cfg_data[15:0];
				REG_CENTER_Y:   center_y_q   <= cfg_data[15:0];
				REG_SKEW:       skew_q       <= signed'(cfg_data[15:0]);
				REG_HALF_WIDTH: half_width_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline moves together; it holds only while the skid is full.
	logic en;
	logic skid_vld_q;
	logic box_vld_q;

	assign en         = !skid_vld_q;
	assign item_ready = en;

	// Stage 1: drop requests without positive depth, shift the points.
	logic                   valid_s1;
	logic signed [PT_W-1:0] xl_s1;
	logic signed [PT_W-1:0] yt_s1;
	side_t                  side_s1;
	logic                   depth_ok;

	assign depth_ok = !item.pos_z[23] && (item.pos_z != '0);

	// Stage 2: every product of the two projections and the size terms.
	logic                    valid_s2;
	logic signed [NUM_W-1:0] p_fx_xl_s2, p_sk_yt_s2, p_cx_z_s2;
	logic signed [NUM_W-1:0] p_fy_yt_s2, p_cy_z_s2;
	logic signed [NUM_W-1:0] p_fx_hw_s2, p_sk_ht_s2, p_fy_ht_s2;
	side_t                   side_s2;

	// Stage 3: numerators of the corner and of the size.
	logic                    valid_s3;
	logic signed [NUM_W-1:0] sum_s3 [NUM_LANES];
	side_t                   side_s3;

	// Stage 4: sign and magnitude for the divider.
	logic                    valid_s4;
	num_t [NUM_LANES-1:0]    num_s4;
	side_t                   side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= item_valid && depth_ok;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xl_s1 <= $signed({item.pos_x[23], item.pos_x}) - $signed({8'b0, half_width_q});
			yt_s1 <= $signed({item.pos_y[23], item.pos_y}) - $signed({7'b0, item.height});
			side_s1.depth       <= item.pos_z[22:0];
			side_s1.body_height <= item.height;
			side_s1.out_id      <= item.person_id;

			p_fx_xl_s2 <= $signed({1'b0, focal_x_q}) * xl_s1;
			p_sk_yt_s2 <= skew_q * yt_s1;
			p_cx_z_s2  <= $signed({1'b0, center_x_q}) * $signed({1'b0, side_s1.depth});
			p_fy_yt_s2 <= $signed({1'b0, focal_y_q}) * yt_s1;
			p_cy_z_s2  <= $signed({1'b0, center_y_q}) * $signed({1'b0, side_s1.depth});
			p_fx_hw_s2 <= $signed({1'b0, focal_x_q}) * $signed({1'b0, half_width_q, 1'b0});
			p_sk_ht_s2 <= skew_q * $signed({1'b0, side_s1.body_height});
			p_fy_ht_s2 <= $signed({1'b0, focal_y_q}) * $signed({1'b0, side_s1.body_height});
			side_s2    <= side_s1;

			sum_s3[LANE_X] <= p_fx_xl_s2 + p_sk_yt_s2 + p_cx_z_s2;
			sum_s3[LANE_Y] <= p_fy_yt_s2 + p_cy_z_s2;
			sum_s3[LANE_W] <= p_fx_hw_s2 + p_sk_ht_s2;
			sum_s3[LANE_H] <= p_fy_ht_s2;
			side_s3        <= side_s2;

			for (int l = 0; l < NUM_LANES; l++) begin
				num_s4[l].neg <= sum_s3[l][NUM_W-1];
				num_s4[l].mag <= sum_s3[l][NUM_W-1] ? MAG_W'(-sum_s3[l]) : MAG_W'(sum_s3[l]);
			end
			side_s4 <= side_s3;
		end
	end

	// Divider
	logic                  div_valid;
	quo_t [NUM_LANES-1:0]  div_quo;
	side_t                 div_side;

	ppbp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.in_den    ({side_s4.depth, 4'b0}),
		.in_num    (num_s4),
		.in_side   (side_s4),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_side  (div_side)
	);

	// A signed corner coordinate saturates to the 16-bit range.
	function automatic logic [15:0] sat_corner(input quo_t q);
		logic [15:0] r;
		if (q.neg) begin
			if (q.ovf || (q.quo > NEG_LIMIT)) begin
				r = 16'h8000;
			end else begin
				r = 16'(-q.quo);
			end
		end else begin
			if (q.ovf || (q.quo > POS_LIMIT)) begin
				r = 16'h7FFF;
			end else begin
				r = q.quo[15:0];
			end
		end
		return r;
	endfunction

	// A size is never negative and saturates at the 16-bit maximum.
	function automatic logic [15:0] sat_size(input quo_t q);
		logic [15:0] r;
		if (q.neg) begin
			r = '0;
		end else if (q.ovf || q.quo[Q_W-1]) begin
			r = 16'hFFFF;
		end else begin
			r = q.quo[15:0];
		end
		return r;
	endfunction

	box_t result;

	always_comb begin
		result.box_x       = signed'(sat_corner(div_quo[LANE_X]));
		result.box_y       = signed'(sat_corner(div_quo[LANE_Y]));
		result.box_w       = sat_size(div_quo[LANE_W]);
		result.box_h       = sat_size(div_quo[LANE_H]);
		result.depth       = div_side.depth;
		result.body_height = div_side.body_height;
		result.out_id      = div_side.out_id;
	end

	// Output register with a one-entry skid buffer behind it.
	box_t box_q;
	box_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (en) begin
			if (div_valid) begin
				if (box_vld_q && !box_ready) begin
					skid_vld_q <= 1'b1;
				end else begin
					box_vld_q <= 1'b1;
				end
			end else if (box_ready) begin
				box_vld_q <= 1'b0;
			end
		end else if (box_ready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (div_valid) begin
				if (box_vld_q && !box_ready) begin
					skid_q <= result;
				end else begin
					box_q <= result;
				end
			end
		end else if (box_ready) begin
			box_q <= skid_q;
		end
	end

	assign box_valid = box_vld_q;
	assign box       = box_q;

`ifndef SYNTHESIS
	a_drop_no_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && (item.pos_z[23] || item.pos_z == '0)) |=> !valid_s1)
		else $error("request without positive depth entered the pipeline");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> box_vld_q)
		else $error("skid buffer holds a result while the output register is empty");

	a_skid_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && box_ready) |=> (box_valid && !skid_vld_q))
		else $error("skid buffer did not move into the output register");

	a_depth_positive: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid |-> (box.depth != '0))
		else $error("result with zero depth delivered");
`endif

endmodule
